// File: hdl/cdsm_pkg.sv
// ---------------------------------------------------------------------------
// cdsm_pkg: shared types and constants for the concentric disk mapper
// Holds the CORDIC arctangent table, gain and angle scale constants.
// ---------------------------------------------------------------------------
package cdsm_pkg;

   localparam int ATAN_COUNT = 24;
   localparam logic signed [31:0] PI4_Q30  = 32'sd843314857;
   localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

   // CORDIC datapath width: Q2.30 plus margin for growth
   localparam int CW = 36;
   // quotient width: |q| <= 65536 plus sign
   localparam int QW = 18;
   // divider width for magnitudes up to 65536
   localparam int DW = 17;

   typedef logic signed [CW-1:0] cval_type;

   function automatic logic [31:0] atan_lut(input logic [4:0] idx);
      logic [31:0] res;
      case (idx)
         5'd0:    res = 32'h3243F6A8;
         5'd1:    res = 32'h1DAC6705;
         5'd2:    res = 32'h0FADBAFC;
         5'd3:    res = 32'h07F56EA6;
         5'd4:    res = 32'h03FEAB76;
         5'd5:    res = 32'h01FFD55B;
         5'd6:    res = 32'h00FFFAAA;
         5'd7:    res = 32'h007FFF55;
         5'd8:    res = 32'h003FFFEA;
         5'd9:    res = 32'h001FFFFD;
         5'd10:   res = 32'h000FFFFF;
         5'd11:   res = 32'h0007FFFF;
         5'd12:   res = 32'h0003FFFF;
         5'd13:   res = 32'h0001FFFF;
         5'd14:   res = 32'h0000FFFF;
         5'd15:   res = 32'h00007FFF;
         5'd16:   res = 32'h00003FFF;
         5'd17:   res = 32'h00001FFF;
         5'd18:   res = 32'h00000FFF;
         5'd19:   res = 32'h000007FF;
         5'd20:   res = 32'h000003FF;
         5'd21:   res = 32'h000001FF;
         5'd22:   res = 32'h000000FF;
         5'd23:   res = 32'h0000007F;
         default: res = 32'h0;
      endcase
      return res;
   endfunction

endpackage

// File: hdl/cdsm_req_if.sv
// ---------------------------------------------------------------------------
// cdsm_req_if: sample pair channel
// Carries valid, ready and the u, v sample payload.
// ---------------------------------------------------------------------------
interface cdsm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_u;
   logic [15:0] sample_v;
   modport source (output valid, output sample_u, output sample_v, input ready);
   modport sink   (input valid, input sample_u, input sample_v, output ready);
endinterface

// File: hdl/cdsm_rsp_if.sv
// ---------------------------------------------------------------------------
// cdsm_rsp_if: disk point channel
// Carries valid, ready and the x, y coordinate payload.
// ---------------------------------------------------------------------------
interface cdsm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] disk_x;
   logic signed [15:0] disk_y;
   modport source (output valid, output disk_x, output disk_y, input ready);
   modport sink   (input valid, input disk_x, input disk_y, output ready);
endinterface

// File: hdl/concentric_disk_sample_map_top.sv
// ---------------------------------------------------------------------------
// concentric_disk_sample_map_top: concentric square-to-disk sample mapper
// Pipelined divider followed by a pipelined rotation CORDIC.
// ---------------------------------------------------------------------------
// Register stages: offsets, 17 divider, multiply, one per CORDIC rotation
// (CORDIC_STEPS, clamped to the atan table size), response. Throughput: one
// transaction per cycle while the response is not stalled; the whole pipe
// advances together.
// The pipe holds when the response register is full and not being taken.
// Reset (synchronous, active high) clears every stage valid bit.
module concentric_disk_sample_map_top #(
   parameter int CORDIC_STEPS = 16
) (
   input logic        clock,
   input logic        reset,
   cdsm_req_if.sink   req,
   cdsm_rsp_if.source rsp
);

   // clamp to table size
   localparam int NS = (CORDIC_STEPS > cdsm_pkg::ATAN_COUNT) ?
                       cdsm_pkg::ATAN_COUNT : CORDIC_STEPS;
   localparam int DW = cdsm_pkg::DW;
   localparam int CW = cdsm_pkg::CW;
   localparam int QW_C = cdsm_pkg::QW;

   // global advance: output register empty or being drained
   logic adv;
   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   // ------------------------------------------------------------------
   // Stage 0: offsets, major axis, magnitudes; loads divider entry 0
   // ------------------------------------------------------------------
   logic [DW:0]     dv_rem_ff [DW+1];
   logic [DW-1:0]   dv_q_ff   [DW+1];
   logic [DW-1:0]   dv_den_ff [DW+1];
   logic            dv_vld_ff [DW+1];
   logic            dv_zero_ff[DW+1];
   logic            dv_swap_ff[DW+1];
   logic            dv_neg_ff [DW+1];
   logic signed [17:0] dv_r_ff[DW+1];

   logic signed [17:0] a_w, b_w;
   logic [DW-1:0]      aa_w, ab_w;
   logic               sw_w;
   assign a_w  = $signed({1'b0, req.sample_u, 1'b0}) - 18'sd65536;
   assign b_w  = $signed({1'b0, req.sample_v, 1'b0}) - 18'sd65536;
   assign aa_w = a_w[17] ? DW'(-a_w) : DW'(a_w);
   assign ab_w = b_w[17] ? DW'(-b_w) : DW'(b_w);
   assign sw_w = !(aa_w > ab_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= req.valid;
      end
      if (adv) begin
         dv_zero_ff[0] <= (a_w == 18'sd0) && (b_w == 18'sd0);
         dv_swap_ff[0] <= sw_w;
         dv_r_ff[0]    <= sw_w ? b_w : a_w;
         dv_rem_ff[0]  <= {1'b0, (sw_w ? aa_w : ab_w)};
         dv_den_ff[0]  <= sw_w ? ab_w : aa_w;
         dv_q_ff[0]    <= '0;
         // quotient sign: sign(num) xor sign(den)
         dv_neg_ff[0]  <= a_w[17] ^ b_w[17];
      end
   end

   // ------------------------------------------------------------------
   // Divider: restoring, one quotient bit per stage, DW stages.
   // Quotient of num*65536/den, num <= den so quotient <= 65536 (17 bits).
   // ------------------------------------------------------------------

   // num < 2*den holds, so quotient bit 16 first, rem shifts left each step
   genvar g;
   generate
      for (g = 0; g < DW; g++) begin : g_div
         logic [DW+1:0] trial_w;
         logic          take_w;
         logic [DW:0]   rem_w;
         // first step uses rem unshifted (bit 16 weight = num/den)
         assign trial_w = (g == 0) ? {1'b0, dv_rem_ff[g]} : {dv_rem_ff[g], 1'b0};
         assign take_w  = trial_w >= {2'b00, dv_den_ff[g]};
         assign rem_w   = take_w ? (DW+1)'(trial_w - {2'b00, dv_den_ff[g]})
                                 : (DW+1)'(trial_w);
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_vld_ff[g+1] <= 1'b0;
            end else if (adv) begin
               dv_vld_ff[g+1] <= dv_vld_ff[g];
            end
            if (adv) begin
               dv_rem_ff[g+1]  <= rem_w;
               dv_q_ff[g+1]    <= {dv_q_ff[g][DW-2:0], take_w};
               dv_den_ff[g+1]  <= dv_den_ff[g];
               dv_zero_ff[g+1] <= dv_zero_ff[g];
               dv_swap_ff[g+1] <= dv_swap_ff[g];
               dv_neg_ff[g+1]  <= dv_neg_ff[g];
               dv_r_ff[g+1]    <= dv_r_ff[g];
            end
         end
      end
   endgenerate

   // ------------------------------------------------------------------
   // Multiply stage: phi = floor(q*PI4/2^16), x0 = floor(r*K/2^16);
   // loads CORDIC entry 0
   // ------------------------------------------------------------------
   cdsm_pkg::cval_type c_x_ff[NS+1], c_y_ff[NS+1], c_z_ff[NS+1];
   logic c_vld_ff[NS+1], c_zero_ff[NS+1], c_swap_ff[NS+1];

   logic signed [QW_C-1:0] q_w;
   logic signed [QW_C+32-1:0] zp_w;
   logic signed [18+32-1:0]   xp_w;
   logic [DW-1:0] qm_w;
   assign qm_w = dv_q_ff[DW];
   assign q_w  = dv_neg_ff[DW] ? -$signed({1'b0, qm_w}) : $signed({1'b0, qm_w});
   assign zp_w = q_w * cdsm_pkg::PI4_Q30;
   assign xp_w = dv_r_ff[DW] * cdsm_pkg::GAIN_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         c_vld_ff[0] <= dv_vld_ff[DW];
      end
      if (adv) begin
         c_zero_ff[0] <= dv_zero_ff[DW];
         c_swap_ff[0] <= dv_swap_ff[DW];
         c_z_ff[0]    <= CW'(zp_w >>> 16);
         c_x_ff[0]    <= CW'(xp_w >>> 16);
         c_y_ff[0]    <= '0;
      end
   end

   // ------------------------------------------------------------------
   // CORDIC rotation pipeline, one micro-rotation per stage
   // ------------------------------------------------------------------
   generate
      for (g = 0; g < NS; g++) begin : g_cor
         cdsm_pkg::cval_type at_w, xs_w, ys_w;
         assign at_w = CW'($signed({1'b0, cdsm_pkg::atan_lut(5'(g))}));
         assign xs_w = c_x_ff[g] >>> g;
         assign ys_w = c_y_ff[g] >>> g;
         always_ff @(posedge clock) begin
            if (reset) begin
               c_vld_ff[g+1] <= 1'b0;
            end else if (adv) begin
               c_vld_ff[g+1] <= c_vld_ff[g];
            end
            if (adv) begin
               if (!c_z_ff[g][CW-1]) begin
                  c_x_ff[g+1] <= c_x_ff[g] - ys_w;
                  c_y_ff[g+1] <= c_y_ff[g] + xs_w;
                  c_z_ff[g+1] <= c_z_ff[g] - at_w;
               end else begin
                  c_x_ff[g+1] <= c_x_ff[g] + ys_w;
                  c_y_ff[g+1] <= c_y_ff[g] - xs_w;
                  c_z_ff[g+1] <= c_z_ff[g] + at_w;
               end
               c_zero_ff[g+1] <= c_zero_ff[g];
               c_swap_ff[g+1] <= c_swap_ff[g];
            end
         end
      end
   endgenerate

   // ------------------------------------------------------------------
   // Output: round, saturate, swap, zero; response register
   // ------------------------------------------------------------------
   function automatic logic signed [15:0] to_q15(input cdsm_pkg::cval_type v);
      cdsm_pkg::cval_type t;
      t = (v + CW'(36'sd16384)) >>> 15;
      if (t > CW'(36'sd32767))       return 16'sd32767;
      else if (t < -CW'(36'sd32768)) return -16'sd32768;
      else                           return t[15:0];
   endfunction

   logic               o_vld_ff;
   logic signed [15:0] o_x_ff, o_y_ff;
   logic signed [15:0] qx_w, qy_w;
   assign qx_w = to_q15(c_x_ff[NS]);
   assign qy_w = to_q15(c_y_ff[NS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         o_vld_ff <= c_vld_ff[NS];
      end
      if (adv) begin
         if (c_zero_ff[NS]) begin
            o_x_ff <= '0;
            o_y_ff <= '0;
         end else if (c_swap_ff[NS]) begin
            o_x_ff <= qy_w;
            o_y_ff <= qx_w;
         end else begin
            o_x_ff <= qx_w;
            o_y_ff <= qy_w;
         end
      end
   end

   assign rsp.valid  = o_vld_ff;
   assign rsp.disk_x = o_x_ff;
   assign rsp.disk_y = o_y_ff;

`ifndef SYNTHESIS
   // a held response stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.disk_x) && $stable(rsp.disk_y))
      else $error("response changed while stalled");
   // a stalled response blocks new requests
   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("request taken while pipe stalled");
`endif

endmodule

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for the concentric disk sample mapper
// Drives sample pairs, predicts each disk point with an independent
// fixed-point square-to-disk model and checks every response in order.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int STEPS     = 16;
   localparam int LATENCY   = 17 + 2 + STEPS + 1;
   localparam int CYCLE_MAX = 400000;

   typedef struct packed {
      logic signed [15:0] disk_x;
      logic signed [15:0] disk_y;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cdsm_req_if req ();
   cdsm_rsp_if rsp ();

   concentric_disk_sample_map_top #(.CORDIC_STEPS(STEPS)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #6 clock = ~clock;

   point_type   point_queue[$];
   int          error_count = 0;
   int          point_count = 0;
   int          cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned take_idle_pct = 0;

   // floor(v / 2^s); >>> on a signed value is already a floor shift
   function automatic longint floor_div_pow2(input longint v, input int s);
      return v >>> s;
   endfunction

   // round to Q1.15 and clamp
   function automatic logic signed [15:0] round_q15(input longint v);
      longint t;
      t = floor_div_pow2(v + (64'sd1 <<< 14), 15);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t[15:0];
   endfunction

   function automatic point_type map_to_disk(input logic [15:0] u, input logic [15:0] v);
      longint a, b, rad, num, den, q, x, y, z, nx, ny;
      bit     swap;
      int     n;
      point_type p;
      a = 2 * longint'(u) - 65536;
      b = 2 * longint'(v) - 65536;
      if (a == 0 && b == 0) begin
         p.disk_x = '0;
         p.disk_y = '0;
         return p;
      end
      if ((a < 0 ? -a : a) > (b < 0 ? -b : b)) begin
         rad = a; num = b; den = a; swap = 0;
      end else begin
         rad = b; num = a; den = b; swap = 1;
      end
      q = (num * 65536) / den;   // truncates toward zero
      z = floor_div_pow2(q * longint'(cdsm_pkg::PI4_Q30), 16);
      x = floor_div_pow2(rad * longint'(cdsm_pkg::GAIN_Q30), 16);
      y = 0;
      n = (STEPS > cdsm_pkg::ATAN_COUNT) ? cdsm_pkg::ATAN_COUNT : STEPS;
      for (int i = 0; i < n; i++) begin
         if (z >= 0) begin
            nx = x - floor_div_pow2(y, i);
            ny = y + floor_div_pow2(x, i);
            z  = z - longint'(cdsm_pkg::atan_lut(i[4:0]));
         end else begin
            nx = x + floor_div_pow2(y, i);
            ny = y - floor_div_pow2(x, i);
            z  = z + longint'(cdsm_pkg::atan_lut(i[4:0]));
         end
         x = nx;
         y = ny;
      end
      if (swap) begin
         p.disk_x = round_q15(y);
         p.disk_y = round_q15(x);
      end else begin
         p.disk_x = round_q15(x);
         p.disk_y = round_q15(y);
      end
      return p;
   endfunction

   // Send one sample pair; the prediction is queued at acceptance.
   // Valid stays high on return so pairs can follow back to back; the idle
   // loop or the drain drops it.
   task automatic send_samples(input logic [15:0] u, input logic [15:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid    <= 1'b1;
      req.sample_u <= u;
      req.sample_v <= v;
      do @(posedge clock); while (!req.ready);
      point_queue.push_back(map_to_disk(u, v));
      @(negedge clock);
   endtask

   // Random receiver stall, redrawn at each falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Compare each accepted point with the oldest prediction.
   always @(posedge clock) begin
      point_type exp_p;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (point_queue.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d", $time, rsp.disk_x, rsp.disk_y);
            error_count++;
         end else begin
            exp_p = point_queue.pop_front();
            point_count++;
            if (rsp.disk_x !== exp_p.disk_x) begin
               $display("%0t: disk_x expected %0d actual %0d", $time,
                        exp_p.disk_x, rsp.disk_x);
               error_count++;
            end
            if (rsp.disk_y !== exp_p.disk_y) begin
               $display("%0t: disk_y expected %0d actual %0d", $time,
                        exp_p.disk_y, rsp.disk_y);
               error_count++;
            end
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_MAX) begin
         $display("%0t: timeout, %0d points outstanding", $time, point_queue.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Corners: origin, both extremes of each axis, the diagonals and ties.
   task automatic test_directed();
      logic [15:0] corner[6];
      corner = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF};
      send_samples(16'h8000, 16'h8000);   // origin
      foreach (corner[i])
         foreach (corner[j])
            if ((i + j) % 2 == 0 || i == j) send_samples(corner[i], corner[j]);
      send_samples(16'hC000, 16'h4000);   // |a| equal |b|, opposite signs
      send_samples(16'h8000, 16'hFFFF);   // a zero, b at max
      send_samples(16'h0000, 16'h8000);   // b zero, a at min
   endtask

   // Uniform pairs, some forced onto the diagonals or near the origin.
   task automatic test_random(input int count);
      logic [15:0] u, v;
      for (int n = 0; n < count; n++) begin
         u = 16'($urandom);
         v = 16'($urandom);
         case ($urandom_range(4))
            0: v = u;
            1: v = 16'hFFFF - u;
            2: begin
               u = 16'(32'h8000 + $urandom_range(8) - 4);
               v = 16'(32'h8000 + $urandom_range(8) - 4);
            end
            default: ;
         endcase
         send_samples(u, v);
      end
   endtask

   // Drop valid, hold until every prediction has been matched, then drain.
   task automatic wait_drained();
      req.valid <= 1'b0;
      while (point_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      req.valid    = 1'b0;
      req.sample_u = '0;
      req.sample_v = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 34; take_idle_pct = 80;
      test_directed();
      test_random(160);
      send_idle_pct = 80; take_idle_pct = 34;
      test_random(160);
      send_idle_pct = 0;  take_idle_pct = 0;
      test_random(180);
      wait_drained();

      $display("Checked %0d disk points: origin, axis extremes, diagonals,", point_count);
      $display("near-origin and uniform samples under three stall patterns.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
